/* rtl/chtl_pkg.sv */
// ----------------------------------------------------------------------------
// chtl_pkg
// Shared types and constants for the chained hash table lookup core.
// ----------------------------------------------------------------------------
package chtl_pkg;

    // Field widths of the request and result channels
    localparam int HASH_W   = 32;
    localparam int OFFSET_W = 16;
    localparam int SLOT_W   = 10;
    localparam int KEY_W    = 32;

    // Bucket remainder before correction; below twice any bucket count up to 1024
    localparam int REM_W = SLOT_W + 2;

    // Operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // One stored table entry
    typedef struct packed {
        logic [HASH_W-1:0]   hash;
        logic [OFFSET_W-1:0] offset;
        logic [SLOT_W-1:0]   next;
    } t_entry;

endpackage

/* rtl/chtl_req_if.sv */
// ----------------------------------------------------------------------------
// chtl_req_if
// Request channel: table writes and key lookups.
// ----------------------------------------------------------------------------
interface chtl_req_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [chtl_pkg::SLOT_W-1:0]   entry_index;
    logic [chtl_pkg::HASH_W-1:0]   entry_hash;
    logic [chtl_pkg::OFFSET_W-1:0] entry_offset;
    logic [chtl_pkg::SLOT_W-1:0]   entry_next;
    logic [chtl_pkg::KEY_W-1:0]    lookup_key;

    modport source (
        output valid, operation, entry_index, entry_hash, entry_offset, entry_next,
               lookup_key,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, entry_hash, entry_offset, entry_next,
               lookup_key,
        output ready
    );
endinterface

/* rtl/chtl_res_if.sv */
// ----------------------------------------------------------------------------
// chtl_res_if
// Result channel: lookup outcome.
// ----------------------------------------------------------------------------
interface chtl_res_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [chtl_pkg::OFFSET_W-1:0] string_offset;

    modport source (
        output valid, found, string_offset,
        input  ready
    );
    modport sink (
        input  valid, found, string_offset,
        output ready
    );
endinterface

/* rtl/chtl_cfg_if.sv */
// ----------------------------------------------------------------------------
// chtl_cfg_if
// Configuration write channel for the table_present register.
// ----------------------------------------------------------------------------
interface chtl_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

/* rtl/chained_hash_table_lookup_core.sv */
// ----------------------------------------------------------------------------
// chained_hash_table_lookup_core
// Hash table with collision chaining held in a 1024-entry on-chip store.
// ----------------------------------------------------------------------------
// A write request stores one entry (hash, offset, chain link). A lookup
// request reads one chain entry per cycle from the single registered read
// port; the result is written to the output register as the walk ends, and
// the block then returns to idle for the next request. With table_present low
// a lookup skips the store and goes straight to a miss result. When
// BUCKET_COUNT is not a power of two, the bucket (key mod BUCKET_COUNT) comes
// from a reciprocal multiply and one correcting subtract, done in the S_QUO
// and S_REM states before the walk starts. The walk reads at most
// TABLE_DEPTH entries. The block takes one request at a time and is not ready
// while a lookup is in progress; a finished result waits in the output
// register while the next request is taken, and a later lookup holds on its
// last entry until that result is accepted. Entries read before they were
// ever written return unspecified data. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module chained_hash_table_lookup_core #(
    parameter int BUCKET_COUNT = 256,
    parameter int TABLE_DEPTH  = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chtl_cfg_if.sink    i_cfg,
    chtl_req_if.sink    i_req,
    chtl_res_if.source  o_res
);

    localparam int SLOT_W   = chtl_pkg::SLOT_W;
    localparam int REM_W    = chtl_pkg::REM_W;
    localparam int OFFSET_W = chtl_pkg::OFFSET_W;
    localparam int KEY_W    = chtl_pkg::KEY_W;
    localparam int SLOTS    = 1 << SLOT_W;
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);

    localparam bit               IS_POW2     = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
    localparam logic [REM_W-1:0]  BUCKET_DIV  = REM_W'(BUCKET_COUNT);
    localparam logic [SLOT_W-1:0] BUCKET_MASK = SLOT_W'(BUCKET_COUNT - 1);
    localparam logic [CNT_W-1:0]  DEPTH_MAX   = CNT_W'(TABLE_DEPTH);
    // floor(2^32 / BUCKET_COUNT); the quotient estimate is at most one low
    localparam logic [KEY_W-1:0]  RECIP       =
        KEY_W'((64'd1 << KEY_W) / 64'(BUCKET_COUNT));

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_QUO  = 3'd1;
    localparam logic [2:0] S_REM  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_MISS = 3'd4;

    logic [2:0]          r_state, n_state;
    logic                r_table_present;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [KEY_W-1:0]    r_quo, n_quo;
    logic [SLOT_W-1:0]   r_ptr, n_ptr;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic                r_found, n_found;
    logic [OFFSET_W-1:0] r_off, n_off;

    chtl_pkg::t_entry    r_mem [SLOTS];
    chtl_pkg::t_entry    r_rdata;

    logic                w_req_acc;
    logic                w_out_free;
    logic [2*KEY_W-1:0]  w_prod;
    logic [REM_W-1:0]    w_qd;
    logic [REM_W-1:0]    w_rem_raw;
    logic [REM_W-1:0]    w_rem;
    logic                w_hit;
    logic [CNT_W-1:0]    w_cnt_inc;
    logic                w_last;

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_res.ready;

    assign o_res.valid         = r_out_valid;
    assign o_res.found         = r_found;
    assign o_res.string_offset = r_off;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_present <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_table_present <= i_cfg.data;
        end
    end

    // Entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_req_acc && i_req.operation == chtl_pkg::OP_WRITE) begin
            r_mem[i_req.entry_index] <= '{hash:   i_req.entry_hash,
                                          offset: i_req.entry_offset,
                                          next:   i_req.entry_next};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[n_ptr];
    end

    // Bucket unit: quotient estimate by reciprocal multiply
    assign w_prod = (2*KEY_W)'(r_key) * (2*KEY_W)'(RECIP);

    // Remainder from the low bits, then one compare and subtract
    assign w_qd      = REM_W'(r_quo[REM_W-1:0] * BUCKET_DIV);
    assign w_rem_raw = r_key[REM_W-1:0] - w_qd;
    assign w_rem     = (w_rem_raw >= BUCKET_DIV) ? (w_rem_raw - BUCKET_DIV) : w_rem_raw;

    // Chain walk compare
    assign w_hit     = (r_rdata.hash == r_key);
    assign w_cnt_inc = r_cnt + CNT_W'(1);
    assign w_last    = (r_rdata.next == '0) || (w_cnt_inc >= DEPTH_MAX);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_quo       = r_quo;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_res.ready;
        n_found     = r_found;
        n_off       = r_off;

        unique case (r_state)
            S_IDLE: begin
                if (w_req_acc && i_req.operation == chtl_pkg::OP_LOOKUP) begin
                    n_key = i_req.lookup_key;
                    n_cnt = '0;
                    if (!r_table_present) begin
                        n_state = S_MISS;
                    end else if (IS_POW2) begin
                        n_ptr   = i_req.lookup_key[SLOT_W-1:0] & BUCKET_MASK;
                        n_state = S_CMP;
                    end else begin
                        n_state = S_QUO;
                    end
                end
            end
            S_QUO: begin
                n_quo   = w_prod[2*KEY_W-1:KEY_W];
                n_state = S_REM;
            end
            S_REM: begin
                n_ptr   = w_rem[SLOT_W-1:0];
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_hit || w_last) begin
                    // Hold here, rereading the same entry, until the output frees up
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_found     = w_hit;
                        n_off       = w_hit ? r_rdata.offset : '0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_ptr = r_rdata.next;
                    n_cnt = w_cnt_inc;
                end
            end
            S_MISS: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_found     = 1'b0;
                    n_off       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ptr       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_ptr       <= n_ptr;
            r_cnt       <= n_cnt;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_quo   <= n_quo;
        r_found <= n_found;
        r_off   <= n_off;
    end

endmodule
